/* rtl/core/rsd_pkg.sv */
package rsd_pkg;

  localparam int FULL_SCALE_DEF = 32767;

  localparam int AXIS_W    = 16;
  localparam int DZ_W      = 17;
  localparam int CFG_IDX_W = 1;

  localparam logic [DZ_W-1:0] DZ_RESET = 17'd4588;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_DZ  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DZ = 1'b1;

  localparam int MAG_W     = 16;
  localparam int FS_W      = 15;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int ROOT_W    = 24;
  localparam int SQ_STAGES = ROOT_W;
  localparam int SQ_REM_W  = ROOT_W + 3;
  localparam int DQ_W      = 24;
  localparam int AXK_W     = MAG_W + ROOT_W;
  localparam int L_W       = 2 * ROOT_W;
  localparam int NUM_W     = AXK_W + FS_W;
  localparam int Q_W       = 15;

  typedef struct packed {
    logic                     sel;
    logic                     sx;
    logic                     sy;
    logic signed [AXIS_W-1:0] px;
    logic signed [AXIS_W-1:0] py;
    logic                     zdz;
    logic                     big;
    logic [MAG_W-1:0]         ax;
    logic [MAG_W-1:0]         ay;
    logic [DQ_W-1:0]          dq;
  } rsd_side_t;

  typedef struct packed {
    logic                     sel;
    logic                     sx;
    logic                     sy;
    logic signed [AXIS_W-1:0] px;
    logic signed [AXIS_W-1:0] py;
    logic                     pass;
    logic                     zero;
  } rsd_tail_t;

endpackage

/* rtl/core/rsd_if.sv */
interface rsd_in_if;
  logic                              valid;
  logic                              ready;
  logic                              stick_select;
  logic signed [rsd_pkg::AXIS_W-1:0] x_in;
  logic signed [rsd_pkg::AXIS_W-1:0] y_in;

  modport source(output valid, stick_select, x_in, y_in, input ready);
  modport sink(input valid, stick_select, x_in, y_in, output ready);
endinterface

interface rsd_out_if;
  logic                              valid;
  logic                              ready;
  logic                              stick_id;
  logic signed [rsd_pkg::AXIS_W-1:0] x_out;
  logic signed [rsd_pkg::AXIS_W-1:0] y_out;

  modport source(output valid, stick_id, x_out, y_out, input ready);
  modport sink(input valid, stick_id, x_out, y_out, output ready);
endinterface

/* rtl/core/rsd_sqrt.sv */
module rsd_sqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rsd_pkg::SQ_W-1:0]    rad,
  output logic [rsd_pkg::ROOT_W-1:0]  root
);
  import rsd_pkg::*;

  logic [SQ_REM_W-1:0] rem_r  [SQ_STAGES];
  logic [ROOT_W-1:0]   root_r [SQ_STAGES];
  logic [SQ_W-1:0]     rad_r  [SQ_STAGES-1];

  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_st
    localparam int P = SQ_STAGES - 1 - j;
    logic [SQ_REM_W-1:0] rem_in;
    logic [SQ_REM_W-1:0] rem_sh;
    logic [SQ_REM_W-1:0] trial;
    logic [ROOT_W-1:0]   root_in;
    logic [SQ_W-1:0]     rad_in;
    logic [2*ROOT_W-1:0] full;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign rad_in  = rad_r[j-1];
    end

    assign full   = {rad_in, {(2*ROOT_W-SQ_W){1'b0}}};
    assign rem_sh = {rem_in[SQ_REM_W-3:0], full[2*P+1 -: 2]};
    assign trial  = SQ_REM_W'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_sh >= trial) begin
          rem_r[j]  <= rem_sh - trial;
          root_r[j] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[j]  <= rem_sh;
          root_r[j] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end

    if (j < SQ_STAGES - 1) begin : g_rad
      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[j] <= rad_in;
        end
      end
    end
  end

  assign root = root_r[SQ_STAGES-1];

endmodule

/* rtl/core/rsd_div.sv */
module rsd_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [rsd_pkg::NUM_W-1:0]  num,
  input  logic [rsd_pkg::L_W-1:0]    den,
  output logic [rsd_pkg::Q_W-1:0]    quo
);
  import rsd_pkg::*;

  localparam int CMP_W = L_W + Q_W;

  logic [NUM_W-1:0] rem_r [Q_W];
  logic [L_W-1:0]   den_r [Q_W-1];
  logic [Q_W-1:0]   q_r   [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_st
    localparam int I = Q_W - 1 - j;
    logic [NUM_W-1:0] rem_in;
    logic [L_W-1:0]   den_in;
    logic [Q_W-1:0]   q_in;
    logic [CMP_W-1:0] remx;
    logic [CMP_W-1:0] dsh;
    logic [CMP_W-1:0] diff;
    logic             ge;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign q_in   = q_r[j-1];
    end

    assign remx = CMP_W'(rem_in);
    assign dsh  = CMP_W'(den_in) << I;
    assign ge   = remx >= dsh;
    assign diff = remx - dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? diff[NUM_W-1:0] : rem_in;
        q_r[j]   <= {q_in[Q_W-2:0], ge};
      end
    end

    if (j < Q_W - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          den_r[j] <= den_in;
        end
      end
    end
  end

  assign quo = q_r[Q_W-1];

endmodule

/* rtl/core/radial_scaled_deadzone.sv */
// Throughput: one sample per cycle; the 45 register stages advance together and
// hold while the output register is full and not taken.
// The depth is set by the 24-stage square root and the 15-stage divider.
// Reset (synchronous, active low) clears all valid bits and loads both dead zones with 4588.
module radial_scaled_deadzone #(
  parameter int FULL_SCALE = rsd_pkg::FULL_SCALE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rsd_in_if.sink                         in_if,
  rsd_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [rsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsd_pkg::DZ_W-1:0]       cfg_wdata
);
  import rsd_pkg::*;

  localparam int LAT = 3 + SQ_STAGES + 2 + Q_W + 1;
  localparam logic [FS_W-1:0] FS = FS_W'(FULL_SCALE);
  localparam logic signed [AXIS_W-1:0] FS_S = AXIS_W'(FULL_SCALE);
  localparam logic [DQ_W-1:0] FS_Q8 = DQ_W'(FULL_SCALE * 256);

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [AXIS_W-1:0] v);
    logic signed [AXIS_W-1:0] n;
    n = -v;
    return v[AXIS_W-1] ? MAG_W'(n) : MAG_W'(v);
  endfunction

  function automatic logic signed [AXIS_W-1:0] clamp_fs(input logic signed [AXIS_W-1:0] v);
    if (v > FS_S) begin
      return FS_S;
    end else if (v < -FS_S) begin
      return -FS_S;
    end
    return v;
  endfunction

  logic            en;
  logic [LAT-1:0]  v_r;
  logic [DZ_W-1:0] dz_left_r;
  logic [DZ_W-1:0] dz_right_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_left_r  <= DZ_RESET;
      dz_right_r <= DZ_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEFT_DZ:  dz_left_r  <= cfg_wdata;
        CFG_RIGHT_DZ: dz_right_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en          = !v_r[LAT-1] || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_if.valid};
    end
  end

  logic [DZ_W-1:0] dz_sel;
  rsd_side_t       s1_r;
  logic [DZ_W-1:0] s1_dz_r;

  assign dz_sel = in_if.stick_select ? dz_right_r : dz_left_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r.sel <= in_if.stick_select;
      s1_r.sx  <= in_if.x_in[AXIS_W-1];
      s1_r.sy  <= in_if.y_in[AXIS_W-1];
      s1_r.px  <= clamp_fs(in_if.x_in);
      s1_r.py  <= clamp_fs(in_if.y_in);
      s1_r.zdz <= dz_sel == '0;
      s1_r.big <= dz_sel[DZ_W-1];
      s1_r.ax  <= mag_of(in_if.x_in);
      s1_r.ay  <= mag_of(in_if.y_in);
      s1_r.dq  <= '0;
      s1_dz_r  <= dz_sel;
    end
  end

  logic [DZ_W+FS_W-1:0] dzp;
  logic [SQ_W-1:0]      sqx;
  logic [SQ_W-1:0]      sqy;
  rsd_side_t            s2_nxt;
  rsd_side_t            s2_r;
  logic [SQ_W-1:0]      sqx_r;
  logic [SQ_W-1:0]      sqy_r;

  assign dzp = s1_dz_r * FS;
  assign sqx = s1_r.ax * s1_r.ax;
  assign sqy = s1_r.ay * s1_r.ay;

  always_comb begin
    s2_nxt    = s1_r;
    s2_nxt.dq = dzp[DQ_W+7:8];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r  <= s2_nxt;
      sqx_r <= sqx;
      sqy_r <= sqy;
    end
  end

  rsd_side_t       s3_r;
  logic [SQ_W-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r  <= s2_r;
      sum_r <= sqx_r + sqy_r;
    end
  end

  logic [ROOT_W-1:0] root;
  rsd_side_t         sb_sq_r [SQ_STAGES];

  rsd_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sum_r),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sb_sq_r[0] <= s3_r;
      for (int i = 1; i < SQ_STAGES; i++) begin
        sb_sq_r[i] <= sb_sq_r[i-1];
      end
    end
  end

  rsd_side_t         sb;
  logic [DQ_W-1:0]   kk;
  logic [DQ_W-1:0]   fsd;
  logic              in_zone;
  logic [L_W-1:0]    lprod;
  logic [AXK_W-1:0]  axk;
  logic [AXK_W-1:0]  ayk;
  rsd_tail_t         t28_r;
  logic [MAG_W-1:0]  ax28_r;
  logic [MAG_W-1:0]  ay28_r;
  logic [L_W-1:0]    l_r;
  logic [AXK_W-1:0]  axk_r;
  logic [AXK_W-1:0]  ayk_r;

  assign sb      = sb_sq_r[SQ_STAGES-1];
  assign kk      = root - sb.dq;
  assign fsd     = FS_Q8 - sb.dq;
  assign in_zone = root <= sb.dq;
  assign lprod   = root * fsd;
  assign axk     = sb.ax * kk;
  assign ayk     = sb.ay * kk;

  always_ff @(posedge clk) begin
    if (en) begin
      t28_r.sel  <= sb.sel;
      t28_r.sx   <= sb.sx;
      t28_r.sy   <= sb.sy;
      t28_r.px   <= sb.px;
      t28_r.py   <= sb.py;
      t28_r.pass <= sb.zdz;
      t28_r.zero <= sb.big || in_zone;
      ax28_r     <= sb.ax;
      ay28_r     <= sb.ay;
      l_r        <= lprod;
      axk_r      <= axk;
      ayk_r      <= ayk;
    end
  end

  logic                  ovf;
  logic [NUM_W-1:0]      nx_nov;
  logic [NUM_W-1:0]      ny_nov;
  logic [MAG_W+FS_W-1:0] nx_ov;
  logic [MAG_W+FS_W-1:0] ny_ov;
  logic [MAG_W-1:0]      bmax;
  rsd_tail_t             t29_r;
  logic [NUM_W-1:0]      numx_r;
  logic [NUM_W-1:0]      numy_r;
  logic [L_W-1:0]        den_r;

  assign ovf    = (L_W'(axk_r) > l_r) || (L_W'(ayk_r) > l_r);
  assign nx_nov = axk_r * FS;
  assign ny_nov = ayk_r * FS;
  assign nx_ov  = ax28_r * FS;
  assign ny_ov  = ay28_r * FS;
  assign bmax   = (ax28_r > ay28_r) ? ax28_r : ay28_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t29_r  <= t28_r;
      numx_r <= ovf ? NUM_W'(nx_ov) : nx_nov;
      numy_r <= ovf ? NUM_W'(ny_ov) : ny_nov;
      den_r  <= ovf ? L_W'(bmax) : l_r;
    end
  end

  logic [Q_W-1:0] qx;
  logic [Q_W-1:0] qy;
  rsd_tail_t      sb_dv_r [Q_W];

  rsd_div u_div_x (
    .clk (clk),
    .en  (en),
    .num (numx_r),
    .den (den_r),
    .quo (qx)
  );

  rsd_div u_div_y (
    .clk (clk),
    .en  (en),
    .num (numy_r),
    .den (den_r),
    .quo (qy)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sb_dv_r[0] <= t29_r;
      for (int i = 1; i < Q_W; i++) begin
        sb_dv_r[i] <= sb_dv_r[i-1];
      end
    end
  end

  rsd_tail_t                tl;
  logic signed [AXIS_W-1:0] qxs;
  logic signed [AXIS_W-1:0] qys;
  logic signed [AXIS_W-1:0] xo;
  logic signed [AXIS_W-1:0] yo;
  logic                     stick_r;
  logic signed [AXIS_W-1:0] x_r;
  logic signed [AXIS_W-1:0] y_r;

  assign tl  = sb_dv_r[Q_W-1];
  assign qxs = AXIS_W'(qx);
  assign qys = AXIS_W'(qy);

  always_comb begin
    if (tl.pass) begin
      xo = tl.px;
      yo = tl.py;
    end else if (tl.zero) begin
      xo = '0;
      yo = '0;
    end else begin
      xo = tl.sx ? -qxs : qxs;
      yo = tl.sy ? -qys : qys;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stick_r <= tl.sel;
      x_r     <= xo;
      y_r     <= yo;
    end
  end

  assign out_if.valid    = v_r[LAT-1];
  assign out_if.stick_id = stick_r;
  assign out_if.x_out    = x_r;
  assign out_if.y_out    = y_r;

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3+SQ_STAGES+1] && !t29_r.pass && !t29_r.zero |-> den_r != '0)
    else $error("divider operand is zero for a scaled sample");

  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[LAT-2] && !tl.pass && !tl.zero |-> (qx <= FS) && (qy <= FS))
    else $error("scaled axis exceeds full scale");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.x_out <= FS_S) && (out_if.x_out >= -FS_S)
                     && (out_if.y_out <= FS_S) && (out_if.y_out >= -FS_S))
    else $error("output transaction outside full scale");

endmodule

/* tb/sv/tb_radial_scaled_deadzone.sv */
module tb_radial_scaled_deadzone;
  timeunit 1ns;
  timeprecision 1ps;
  import rsd_pkg::*;

  localparam int FS = FULL_SCALE_DEF;
  localparam int PIPE_LAT = 44;

  typedef struct packed {
    logic                     stick;
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
  } stick_sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_LEFT_DZ;
  logic [DZ_W-1:0] cfg_wdata = '0;

  rsd_in_if in_ch();
  rsd_out_if out_ch();

  radial_scaled_deadzone DUT (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  logic [DZ_W-1:0] zone_left = DZ_RESET;
  logic [DZ_W-1:0] zone_right = DZ_RESET;
  stick_sample_t pending_outputs[$];
  int error_count = 0;
  int result_count = 0;
  int sent_count = 0;
  bit idle_enable = 1'b1;
  bit hold_output = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.stick_select = 1'b0;
    in_ch.x_in = '0;
    in_ch.y_in = '0;
    out_ch.ready = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic signed [AXIS_W-1:0] signed_axis(longint raw,
                                                            longint unsigned mag);
    longint r;
    r = (raw < 0) ? -longint'(mag) : longint'(mag);
    return r[AXIS_W-1:0];
  endfunction

  function automatic stick_sample_t condition_sample(stick_sample_t s);
    stick_sample_t r;
    longint x, y;
    longint unsigned zone, ax, ay, sq, mag, dq, k, l, big;
    x = longint'(s.x);
    y = longint'(s.y);
    zone = 64'(s.stick ? zone_right : zone_left);
    r.stick = s.stick;
    r.x = '0;
    r.y = '0;
    if (zone == 0) begin
      r.x = AXIS_W'((x < -FS) ? longint'(-FS) : x);
      r.y = AXIS_W'((y < -FS) ? longint'(-FS) : y);
    end else if (zone < 65536) begin
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      sq = ax * ax + ay * ay;
      mag = int_sqrt(sq << 16);
      dq = (zone * FS) >> 8;
      if (mag > dq) begin
        k = mag - dq;
        l = mag * ((longint'(FS) << 8) - dq);
        if (ax * k > l || ay * k > l) begin
          big = (ax > ay) ? ax : ay;
          r.x = signed_axis(x, ax * FS / big);
          r.y = signed_axis(y, ay * FS / big);
        end else begin
          r.x = signed_axis(x, ax * k * FS / l);
          r.y = signed_axis(y, ay * k * FS / l);
        end
      end
    end
    return r;
  endfunction

  task automatic send_sample(logic stick, logic signed [AXIS_W-1:0] x,
                             logic signed [AXIS_W-1:0] y);
    stick_sample_t s;
    int gap;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s.stick = stick;
    s.x = x;
    s.y = y;
    in_ch.valid <= 1'b1;
    in_ch.stick_select <= stick;
    in_ch.x_in <= x;
    in_ch.y_in <= y;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_outputs.push_back(condition_sample(s));
    sent_count++;
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain_and_settle();
    int waited;
    end_burst();
    waited = 0;
    while (pending_outputs.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic write_zone(logic [CFG_IDX_W-1:0] idx, logic [DZ_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LEFT_DZ) zone_left = val;
    else zone_right = val;
    @(posedge clk);
  endtask

  function automatic logic signed [AXIS_W-1:0] random_axis();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sd32767;
      2: return -16'sd32767;
      3: return AXIS_W'(int'($urandom_range(0, 600)) - 300);
      default: return AXIS_W'($urandom());
    endcase
  endfunction

  task automatic random_burst(int count);
    for (int i = 0; i < count; i++)
      send_sample(1'($urandom_range(0, 1)), random_axis(), random_axis());
  endtask

  task automatic test_directed_edges();
    logic signed [AXIS_W-1:0] vals[7] = '{16'sh8000, -16'sd32767, -16'sd1, 16'sd0,
                                          16'sd1, 16'sd300, 16'sd32767};
    for (int i = 0; i < 7; i++) begin
      send_sample(i[0], vals[i], vals[6 - i]);
      send_sample(~i[0], vals[i], 16'sd0);
    end
    send_sample(1'b0, 16'sd2000, 16'sd2000);
    send_sample(1'b1, 16'sd32767, 16'sd32767);
    send_sample(1'b0, 16'sh8000, 16'sh8000);
    drain_and_settle();
  endtask

  task automatic test_zone_settings();
    logic [DZ_W-1:0] zones[6] = '{17'd0, 17'd65536, 17'd65535, 17'd1, 17'd131071,
                                  17'd20000};
    for (int i = 0; i < 6; i++) begin
      write_zone(CFG_LEFT_DZ, zones[i]);
      write_zone(CFG_RIGHT_DZ, zones[5 - i]);
      send_sample(1'b0, 16'sh8000, 16'sd32767);
      send_sample(1'b1, -16'sd32767, 16'sd5);
      random_burst(40);
      drain_and_settle();
    end
  endtask

  task automatic test_backpressure();
    write_zone(CFG_LEFT_DZ, 17'd4588);
    write_zone(CFG_RIGHT_DZ, 17'd9000);
    hold_output = 1'b1;
    random_burst(120);
    drain_and_settle();
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 12; i++) begin
      write_zone(CFG_LEFT_DZ, DZ_W'($urandom_range(0, 131071)));
      write_zone(CFG_RIGHT_DZ, (i % 3 == 0) ? 17'd0 : DZ_W'($urandom_range(1, 40000)));
      if (i == 10) idle_enable = 1'b0;
      random_burst(120);
      drain_and_settle();
    end
  endtask

  always @(posedge clk) begin
    int gap;
    if (hold_output) begin
      out_ch.ready <= 1'b0;
      repeat (300) @(posedge clk);
      hold_output = 1'b0;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      out_ch.ready <= 1'b0;
      repeat (gap) @(posedge clk);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    stick_sample_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_count++;
      if (pending_outputs.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result stick=%0d x=%0d y=%0d", $time,
                 out_ch.stick_id, out_ch.x_out, out_ch.y_out);
      end else begin
        want = pending_outputs.pop_front();
        if (out_ch.stick_id !== want.stick || out_ch.x_out !== want.x ||
            out_ch.y_out !== want.y) begin
          error_count++;
          $display("%0t: mismatch expected stick=%0d x=%0d y=%0d actual stick=%0d x=%0d y=%0d",
                   $time, want.stick, want.x, want.y, out_ch.stick_id,
                   out_ch.x_out, out_ch.y_out);
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_zone_settings();
    test_backpressure();
    test_random_mix();
    if (pending_outputs.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected results never arrived", $time, pending_outputs.size());
    end
    $display("Sent %0d stick samples over many dead zone settings, including zero,", sent_count);
    $display("full and over-range zones, with %0d results checked.", result_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/rsd_pkg.sv
rtl/core/rsd_if.sv
rtl/core/rsd_sqrt.sv
rtl/core/rsd_div.sv
rtl/core/radial_scaled_deadzone.sv
tb/sv/tb_radial_scaled_deadzone.sv
